FILE: rtl/assert_macros.svh
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define DQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// checked at every edge, reset included
`define DQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/dq_pkg.sv
`default_nettype none
package dq_pkg;

  localparam int DEPTH  = 64;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int KIND_W = 2;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_REAR  = 2'd0,
    KIND_PUSH_FRONT = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_POP_REAR   = 2'd3
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic              push_front;
    logic              pop_front;
    logic              push_rear;
    logic              pop_rear;
    logic [WORD_W-1:0] value;
  } cell_cmd_t;

endpackage
`default_nettype wire

FILE: rtl/dq_if.sv
`default_nettype none
interface dq_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] push_value;

  modport source (output valid, output kind, output push_value, input ready);
  modport sink (input valid, input kind, input push_value, output ready);
endinterface

interface dq_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pop_value;
  logic [1:0]         status;
  logic [6:0]         occupancy;

  modport source (output valid, output pop_value, output status, output occupancy,
                  input ready);
  modport sink (input valid, input pop_value, input status, input occupancy,
                output ready);
endinterface
`default_nettype wire

FILE: rtl/double_ended_queue.sv
// output: a result sits in the output register in the cycle after its transaction
// throughput: one operation per cycle while results are taken; every operation
// updates the whole cell row together, front at cell 0
// reset: cell valid bits, occupancy count and output valid clear at once;
// cell words are not cleared, so there is no clearing pass
`default_nettype none
`include "assert_macros.svh"
module double_ended_queue (
  input logic clk_i,
  input logic rst_ni,
  dq_in_if.sink    in_i,
  dq_out_if.source out_o
);
  import dq_pkg::*;

  logic [DEPTH-1:0]  cell_valid;
  logic [WORD_W-1:0] cell_data [DEPTH];
  logic [WORD_W-1:0] cell_rear [DEPTH];
  logic [WORD_W-1:0] rear_word;
  cell_cmd_t         cmd;

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              full, empty, accept;
  kind_e             kind;

  logic              out_valid_q, out_valid_d;
  logic [WORD_W-1:0] pop_q, pop_d;
  status_e           status_q, status_d;

  assign full   = (cnt_q == CNT_W'(DEPTH));
  assign empty  = (cnt_q == '0);
  assign kind   = kind_e'(in_i.kind);
  assign accept = in_i.valid & in_i.ready;
  assign in_i.ready = ~out_valid_q | out_o.ready;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic              lv, rv;
    logic [WORD_W-1:0] ld, rd;
    if (i == 0) begin : g_first
      assign lv = 1'b1;
      assign ld = cmd.value;
    end else begin : g_mid
      assign lv = cell_valid[i-1];
      assign ld = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rv = 1'b0;
      assign rd = '0;
    end else begin : g_notlast
      assign rv = cell_valid[i+1];
      assign rd = cell_data[i+1];
    end
    dq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .left_valid_i (lv),
      .left_data_i  (ld),
      .right_valid_i(rv),
      .right_data_i (rd),
      .valid_o      (cell_valid[i]),
      .data_o       (cell_data[i]),
      .rear_data_o  (cell_rear[i])
    );
  end

  // only the rear cell drives a nonzero word
  always_comb begin
    rear_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_word = rear_word | cell_rear[i];
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.value      = in_i.push_value;
    cnt_d          = cnt_q;
    pop_d          = pop_q;
    status_d       = status_q;
    out_valid_d    = out_valid_q & ~out_o.ready;
    if (accept) begin
      out_valid_d = 1'b1;
      pop_d       = '0;
      status_d    = ST_DONE;
      unique case (kind)
        KIND_PUSH_REAR: begin
          if (full) begin
            status_d = ST_OVERFLOW;
          end else begin
            cmd.push_rear = 1'b1;
            cnt_d         = cnt_q + CNT_W'(1);
          end
        end
        KIND_PUSH_FRONT: begin
          if (full) begin
            status_d = ST_OVERFLOW;
          end else begin
            cmd.push_front = 1'b1;
            cnt_d          = cnt_q + CNT_W'(1);
          end
        end
        KIND_POP_FRONT: begin
          if (empty) begin
            status_d = ST_UNDERFLOW;
          end else begin
            cmd.pop_front = 1'b1;
            pop_d         = cell_data[0];
            cnt_d         = cnt_q - CNT_W'(1);
          end
        end
        KIND_POP_REAR: begin
          if (empty) begin
            status_d = ST_UNDERFLOW;
          end else begin
            cmd.pop_rear = 1'b1;
            pop_d        = rear_word;
            cnt_d        = cnt_q - CNT_W'(1);
          end
        end
        default: begin
          status_d = ST_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_DONE;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pop_q <= pop_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.pop_value = pop_q;
  assign out_o.status    = status_q;
  assign out_o.occupancy = OCC_W'(cnt_q);

  `DQ_ASSERT(a_count_matches_cells, clk_i, rst_ni, $countones(cell_valid) == cnt_q, "occupancy count disagrees with cell valid bits")
  `DQ_ASSERT(a_cells_packed_front, clk_i, rst_ni, ((cell_valid + DEPTH'(1)) & cell_valid) == '0, "occupied cells are not packed toward the front")
  `DQ_ASSERT(a_full_push_refused, clk_i, rst_ni, accept && full && (kind == KIND_PUSH_REAR || kind == KIND_PUSH_FRONT) |=> out_valid_q && status_q == ST_OVERFLOW && full, "push to a full deque was not refused")
  `DQ_ASSERT(a_underflow_zero, clk_i, rst_ni, out_valid_q && status_q == ST_UNDERFLOW |-> pop_q == '0, "underflow result carries a nonzero word")
endmodule
`default_nettype wire

FILE: rtl/dq_cell.sv
`default_nettype none
module dq_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dq_pkg::cell_cmd_t         cmd_i,
  input  logic                      left_valid_i,
  input  logic [dq_pkg::WORD_W-1:0] left_data_i,
  input  logic                      right_valid_i,
  input  logic [dq_pkg::WORD_W-1:0] right_data_i,
  output logic                      valid_o,
  output logic [dq_pkg::WORD_W-1:0] data_o,
  output logic [dq_pkg::WORD_W-1:0] rear_data_o
);
  import dq_pkg::*;

  logic              valid_q, valid_d;
  logic [WORD_W-1:0] data_q, data_d;
  logic              last;

  // rear word: occupied here, empty to the right
  assign last = valid_q & ~right_valid_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    priority if (cmd_i.push_front) begin
      valid_d = left_valid_i;
      data_d  = left_data_i;
    end else if (cmd_i.pop_front) begin
      valid_d = right_valid_i;
      data_d  = right_data_i;
    end else if (cmd_i.push_rear && !valid_q && left_valid_i) begin
      valid_d = 1'b1;
      data_d  = cmd_i.value;
    end else if (cmd_i.pop_rear && last) begin
      valid_d = 1'b0;
    end else begin
      // idle or the transaction lands in another cell
      valid_d = valid_q;
      data_d  = data_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o     = valid_q;
  assign data_o      = data_q;
  assign rear_data_o = last ? data_q : '0;
endmodule
`default_nettype wire
